// ----- rtl/svmc_pkg.sv -----
// Shared constants, codes, command and status types for the state vector block.
`default_nettype none

package svmc_pkg;

  // Sizes of the state vector and of the arithmetic.
  localparam int unsigned MAX_QUBITS = 10;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned DEPTH      = 1 << MAX_QUBITS;
  localparam int unsigned IDX_W      = MAX_QUBITS;
  localparam int unsigned QC_W       = 4;
  localparam int unsigned TGT_W      = 4;
  localparam int unsigned RND_W      = 31;
  localparam int unsigned PROB_W     = 32;
  localparam int unsigned ACC_W      = 42;
  localparam int unsigned MUL_W      = 49;
  localparam int unsigned QUO_W      = 63;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned WORD_W     = 2 * AMP_W;

  localparam int AMP_MAX = (1 << (AMP_W - 1)) - 1;
  localparam int AMP_MIN = -(1 << (AMP_W - 1));

  // Saturated one, as stored in the real part of the ground state.
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(AMP_MAX);
  // Probability one in unsigned Q12.30.
  localparam logic [ACC_W-1:0] PROB_ONE = ACC_W'(1) << 30;

  // Operation codes.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_WRITE      = 3'd0;
  localparam kind_t KIND_READ       = 3'd1;
  localparam kind_t KIND_MEAS_ALL   = 3'd2;
  localparam kind_t KIND_MEAS_QUBIT = 3'd3;
  localparam kind_t KIND_GROUND     = 3'd4;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_OOR   = 2'd1;
  localparam status_t STAT_ZERO  = 2'd2;
  localparam status_t STAT_NONE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic host_wr;
    logic clear_start;
    logic scan_start;
    logic root_start;
    logic scale_start;
    logic rsp_load;
  } svmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  idx_oor;
    logic  found;
    logic  p_zero;
    logic  busy;
    logic  root_busy;
    logic  rsp_free;
  } svmc_stat_t;

  // Round half up by 2^16 and saturate to the amplitude range.
  function automatic logic [AMP_W-1:0] round_sat(input logic signed [MUL_W-1:0] m);
    logic signed [MUL_W-1:0]  v;
    logic signed [MUL_W-17:0] q;
    logic [AMP_W-1:0]         r;
    v = m + MUL_W'(1 << 15);
    q = v[MUL_W-1:16];
    if (q > (MUL_W-16)'(AMP_MAX)) begin
      r = AMP_W'(AMP_MAX);
    end else if (q < (MUL_W-16)'(AMP_MIN)) begin
      r = AMP_W'(AMP_MIN);
    end else begin
      r = q[AMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/svmc_if.sv -----
// Request and response channel interfaces of the state vector block.
`default_nettype none

interface svmc_req_if import svmc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic [IDX_W-1:0]        basis_index;
  logic signed [AMP_W-1:0] amp_real;
  logic signed [AMP_W-1:0] amp_imag;
  logic [TGT_W-1:0]        target_qubit;
  logic [RND_W-1:0]        random_fraction;

  modport source (output valid, kind, basis_index, amp_real, amp_imag, target_qubit,
                  random_fraction, input ready);
  modport sink (input valid, kind, basis_index, amp_real, amp_imag, target_qubit,
                random_fraction, output ready);
endinterface

interface svmc_rsp_if import svmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic [IDX_W-1:0]  outcome_index;
  logic              outcome_bit;
  status_t           status;

  modport source (output valid, probability, outcome_index, outcome_bit, status,
                  input ready);
  modport sink (input valid, probability, outcome_index, outcome_bit, status,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/svmc_rsqrt.sv -----
// Iterative unit for floor(sqrt(floor(2^62 / p))): restoring divide, then bitwise root.
`default_nettype none

module svmc_rsqrt import svmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ACC_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_DIV, PH_SQRT} phase_e;

  phase_e             phase_q;
  logic [5:0]         cnt_q;
  logic [ACC_W-1:0]   d_q;
  logic [ACC_W-1:0]   rem_q;
  logic [QUO_W-1:0]   x_q;
  logic [QUO_W:0]     res_q;
  logic [QUO_W-1:0]   bit_q;
  logic [ROOT_W-1:0]  root_q;

  logic [ACC_W:0]     rem_sh;
  logic               div_ge;
  logic [ACC_W:0]     rem_sub;
  logic [QUO_W:0]     trial;
  logic               sq_ge;
  logic [QUO_W:0]     res_nx;

  // One quotient bit per cycle; the dividend is a single one at the top bit.
  always_comb begin
    rem_sh  = {rem_q, (cnt_q == 6'(QUO_W - 1))};
    div_ge  = rem_sh >= {1'b0, d_q};
    rem_sub = rem_sh - {1'b0, d_q};
  end

  // One root bit per cycle.
  always_comb begin
    trial  = res_q + {1'b0, bit_q};
    sq_ge  = {1'b0, x_q} >= trial;
    res_nx = sq_ge ? ((res_q >> 1) + {1'b0, bit_q}) : (res_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      x_q     <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      root_q  <= '0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_DIV;
            cnt_q   <= 6'(QUO_W - 1);
            d_q     <= divisor_i;
            rem_q   <= '0;
            x_q     <= '0;
          end
        end
        PH_DIV: begin
          rem_q <= div_ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
          x_q   <= {x_q[QUO_W-2:0], div_ge};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            phase_q <= PH_SQRT;
            res_q   <= '0;
            bit_q   <= QUO_W'(1) << (QUO_W - 1);
          end
        end
        PH_SQRT: begin
          if (sq_ge) begin
            x_q <= x_q - trial[QUO_W-1:0];
          end
          res_q <= res_nx;
          bit_q <= bit_q >> 2;
          if (bit_q == QUO_W'(1)) begin
            phase_q <= PH_IDLE;
            root_q  <= res_nx[ROOT_W-1:0];
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign busy_o = (phase_q != PH_IDLE);
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- rtl/svmc_datapath.sv -----
// Amplitude memory, scan and scale pipeline, accumulator and response register.
`default_nettype none

module svmc_datapath import svmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  svmc_cmd_t               cmd_i,
  output svmc_stat_t              stat_o,
  input  logic [QC_W-1:0]         qubit_count_i,
  input  kind_t                   kind_i,
  input  logic [IDX_W-1:0]        basis_index_i,
  input  logic signed [AMP_W-1:0] amp_real_i,
  input  logic signed [AMP_W-1:0] amp_imag_i,
  input  logic [TGT_W-1:0]        target_qubit_i,
  input  logic [RND_W-1:0]        random_fraction_i,
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [PROB_W-1:0]       probability_o,
  output logic [IDX_W-1:0]        outcome_index_o,
  output logic                    outcome_bit_o,
  output status_t                 status_o
);

  typedef enum logic [1:0] {MD_CLEAR, MD_SUM, MD_SCALE} mode_e;

  // Latched item.
  kind_t                   kind_q;
  logic [IDX_W-1:0]        idx_q;
  logic [AMP_W-1:0]        re_q;
  logic [AMP_W-1:0]        im_q;
  logic [TGT_W-1:0]        tgt_q;
  logic [RND_W-1:0]        rnd_q;

  // Address sequencer and pipeline.
  mode_e                   mode_q;
  logic                    run_q;
  logic [IDX_W:0]          cnt_q;
  logic [IDX_W:0]          end_q;
  logic                    s1_v_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic [WORD_W-1:0]       rdata_q;
  logic                    s2_v_q;
  logic [IDX_W-1:0]        s2_idx_q;
  logic signed [MUL_W-1:0] mr_q;
  logic signed [MUL_W-1:0] mi_q;
  logic [ACC_W-1:0]        acc_q;
  logic                    found_q;
  logic [IDX_W-1:0]        oidx_q;

  // Response register.
  logic                    rsp_valid_q;
  logic [PROB_W-1:0]       prob_q;
  logic [IDX_W-1:0]        oidx_out_q;
  logic                    obit_q;
  status_t                 status_q;

  logic [WORD_W-1:0]       mem_q [DEPTH];

  logic [IDX_W:0]          dim;
  logic                    idx_oor;
  logic [IDX_W:0]          cnt_nx;
  logic signed [AMP_W-1:0] rd_re;
  logic signed [AMP_W-1:0] rd_im;
  logic signed [32:0]      mul_b_re;
  logic signed [32:0]      mul_b_im;
  logic signed [MUL_W-1:0] mr_d;
  logic signed [MUL_W-1:0] mi_d;
  logic [IDX_W-1:0]        s2_shift;
  logic                    s2_bit;
  logic [PROB_W-1:0]       p_item;
  logic [ACC_W-1:0]        acc_new;
  logic                    outcome;
  logic [ACC_W-1:0]        p_sel;
  logic                    p_zero;
  logic [IDX_W-1:0]        keep_idx;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [WORD_W-1:0]       mem_wdata;
  logic                    root_busy;
  logic [ROOT_W-1:0]       root;
  status_t                 status_d;

  // Active length and range check.
  always_comb begin
    dim     = (IDX_W+1)'(1) << qubit_count_i;
    idx_oor = {1'b0, idx_q} >= dim;
    cnt_nx  = cnt_q + (IDX_W+1)'(1);
  end

  // Products: squares while summing, amplitude times scale while rescaling.
  always_comb begin
    rd_re    = rdata_q[AMP_W-1:0];
    rd_im    = rdata_q[WORD_W-1:AMP_W];
    mul_b_re = (mode_q == MD_SCALE) ? $signed({1'b0, root}) : 33'(rd_re);
    mul_b_im = (mode_q == MD_SCALE) ? $signed({1'b0, root}) : 33'(rd_im);
    mr_d     = rd_re * mul_b_re;
    mi_d     = rd_im * mul_b_im;
  end

  // Accumulate and decide.
  always_comb begin
    s2_shift = s2_idx_q >> tgt_q;
    s2_bit   = s2_shift[0];
    p_item   = mr_q[PROB_W-1:0] + mi_q[PROB_W-1:0];
    acc_new  = acc_q;
    if ((kind_q != KIND_MEAS_QUBIT) || s2_bit) begin
      acc_new = acc_q + ACC_W'(p_item);
    end
    outcome = ACC_W'(rnd_q) < acc_q;
    if (outcome) begin
      p_sel = acc_q;
    end else if (acc_q >= PROB_ONE) begin
      p_sel = '0;
    end else begin
      p_sel = PROB_ONE - acc_q;
    end
    p_zero   = (p_sel == '0);
    keep_idx = (kind_q == KIND_MEAS_ALL) ? oidx_q : '0;
  end

  // Write port: clearing sweep, rescaled words or a host write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {im_q, re_q};
    if (run_q && (mode_q == MD_CLEAR)) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[IDX_W-1:0];
      mem_wdata = (cnt_q[IDX_W-1:0] == keep_idx) ? {{AMP_W{1'b0}}, AMP_ONE} : '0;
    end else if (s2_v_q && (mode_q == MD_SCALE)) begin
      mem_we    = 1'b1;
      mem_waddr = s2_idx_q;
      mem_wdata = (s2_bit == outcome) ? {round_sat(mi_q), round_sat(mr_q)} : '0;
    end else if (cmd_i.host_wr) begin
      mem_we    = 1'b1;
    end
  end

  // Amplitude memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[cnt_q[IDX_W-1:0]];
  end

  svmc_rsqrt u_rsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.root_start),
    .divisor_i (p_sel),
    .busy_o    (root_busy),
    .root_o    (root)
  );

  // Status of the finished item.
  always_comb begin
    case (kind_q)
      KIND_WRITE, KIND_READ: status_d = idx_oor ? STAT_OOR : STAT_OK;
      KIND_MEAS_ALL:         status_d = found_q ? STAT_OK : STAT_NONE;
      KIND_MEAS_QUBIT:       status_d = p_zero ? STAT_ZERO : STAT_OK;
      default:               status_d = STAT_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_GROUND;
      idx_q       <= '0;
      re_q        <= '0;
      im_q        <= '0;
      tgt_q       <= '0;
      rnd_q       <= '0;
      mode_q      <= MD_CLEAR;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      end_q       <= '0;
      s1_v_q      <= 1'b0;
      s1_idx_q    <= '0;
      s2_v_q      <= 1'b0;
      s2_idx_q    <= '0;
      mr_q        <= '0;
      mi_q        <= '0;
      acc_q       <= '0;
      found_q     <= 1'b0;
      oidx_q      <= '0;
      rsp_valid_q <= 1'b0;
      prob_q      <= '0;
      oidx_out_q  <= '0;
      obit_q      <= 1'b0;
      status_q    <= STAT_OK;
    end else begin
      // Capture the accepted beat.
      if (cmd_i.load) begin
        kind_q <= kind_i;
        idx_q  <= basis_index_i;
        re_q   <= amp_real_i;
        im_q   <= amp_imag_i;
        tgt_q  <= target_qubit_i;
        rnd_q  <= random_fraction_i;
      end

      // Address sequencer.
      if (cmd_i.clear_start) begin
        mode_q <= MD_CLEAR;
        cnt_q  <= '0;
        end_q  <= (IDX_W+1)'(DEPTH);
        run_q  <= 1'b1;
      end else if (cmd_i.scan_start) begin
        mode_q  <= MD_SUM;
        run_q   <= 1'b1;
        acc_q   <= '0;
        found_q <= 1'b0;
        oidx_q  <= '0;
        if (kind_q == KIND_READ) begin
          cnt_q <= {1'b0, idx_q};
          end_q <= {1'b0, idx_q} + (IDX_W+1)'(1);
        end else begin
          cnt_q <= '0;
          end_q <= dim;
        end
      end else if (cmd_i.scale_start) begin
        mode_q <= MD_SCALE;
        cnt_q  <= '0;
        end_q  <= dim;
        run_q  <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_nx;
        if (cnt_nx == end_q) begin
          run_q <= 1'b0;
        end
      end

      // Read and multiply stages.
      s1_v_q   <= run_q && (mode_q != MD_CLEAR);
      s1_idx_q <= cnt_q[IDX_W-1:0];
      s2_v_q   <= s1_v_q;
      s2_idx_q <= s1_idx_q;
      mr_q     <= mr_d;
      mi_q     <= mi_d;

      // Accumulate and catch the first index whose running sum reaches the fraction.
      if (s2_v_q && (mode_q == MD_SUM)) begin
        acc_q <= acc_new;
        if ((kind_q == KIND_MEAS_ALL) && !found_q && (ACC_W'(rnd_q) <= acc_new)) begin
          found_q <= 1'b1;
          oidx_q  <= s2_idx_q;
        end
      end

      // Response register.
      if (cmd_i.rsp_load) begin
        rsp_valid_q <= 1'b1;
        prob_q      <= ((kind_q == KIND_READ) && !idx_oor) ? acc_q[PROB_W-1:0] : '0;
        oidx_out_q  <= ((kind_q == KIND_MEAS_ALL) && found_q) ? oidx_q : '0;
        obit_q      <= (kind_q == KIND_MEAS_QUBIT) && outcome;
        status_q    <= status_d;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.kind      = kind_q;
    stat_o.idx_oor   = idx_oor;
    stat_o.found     = found_q;
    stat_o.p_zero    = p_zero;
    stat_o.busy      = run_q || s1_v_q || s2_v_q;
    stat_o.root_busy = root_busy;
    stat_o.rsp_free  = !rsp_valid_q || rsp_ready_i;
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign probability_o   = prob_q;
  assign outcome_index_o = oidx_out_q;
  assign outcome_bit_o   = obit_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

// ----- rtl/svmc_ctrl.sv -----
// Controller state machine that sequences each operation over the datapath.
`default_nettype none

module svmc_ctrl import svmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  svmc_stat_t stat_i,
  output svmc_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_BOOT, ST_BOOT_WAIT, ST_IDLE, ST_EXEC, ST_SCAN, ST_ROOT, ST_SCALE, ST_CLEAR, ST_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_BOOT: begin
        cmd_o.clear_start = 1'b1;
        state_d           = ST_BOOT_WAIT;
      end
      ST_BOOT_WAIT: begin
        if (!stat_i.busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.kind)
          KIND_WRITE: begin
            cmd_o.host_wr = !stat_i.idx_oor;
            state_d       = ST_DONE;
          end
          KIND_READ: begin
            if (stat_i.idx_oor) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          KIND_MEAS_ALL, KIND_MEAS_QUBIT: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          KIND_GROUND: begin
            cmd_o.clear_start = 1'b1;
            state_d           = ST_CLEAR;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (!stat_i.busy) begin
          state_d = ST_DONE;
          if ((stat_i.kind == KIND_MEAS_ALL) && stat_i.found) begin
            cmd_o.clear_start = 1'b1;
            state_d           = ST_CLEAR;
          end else if ((stat_i.kind == KIND_MEAS_QUBIT) && !stat_i.p_zero) begin
            cmd_o.root_start = 1'b1;
            state_d          = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (!stat_i.root_busy) begin
          cmd_o.scale_start = 1'b1;
          state_d           = ST_SCALE;
        end
      end
      ST_SCALE, ST_CLEAR: begin
        if (!stat_i.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/state_vector_measure_collapse.sv -----
// Quantum state vector with probability read, full measurement and single-qubit collapse.
//
// Usage: items arrive on req_i and each one yields exactly one beat on rsp_o.
// The qubit count is set through the APB port at address 0 (values outside
// 1..10 are clamped) and may only change while no item is in flight.
// Items are handled one at a time; req_i.ready is high whenever the
// sequencer is idle, even if the previous result still waits on rsp_o.
// Steps from acceptance to the result beat, with N = 2^qubit_count:
//   write amplitude      a single memory write
//   read probability     one pass through the memory pipeline
//   measure all          sum walk over N words, plus the collapse sweep
//   measure qubit        sum walk over N words, divide (63 steps) and root
//                        (32 steps) in the iterative unit, then the rescale walk
//   reset ground state   sweep over all 1024 memory words
// The next item can be accepted in the cycle after the result is loaded.
// The memory has one read and one write port, so each walk moves one word a cycle.
// After reset the block sweeps the whole memory to the ground state and
// holds req_i.ready low meanwhile; APB writes are taken during that time.
// When the receiver stalls, the result holds on rsp_o and the block finishes
// its next item up to the response, then waits for the output register.
`default_nettype none

module state_vector_measure_collapse import svmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  svmc_req_if.sink          req_i,
  svmc_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [QC_W-1:0] qubit_count_q;
  logic [QC_W-1:0] qubit_count_d;
  logic [QC_W-1:0] wr_val;
  logic            cfg_wr;
  svmc_cmd_t       cmd;
  svmc_stat_t      stat;

  // Qubit count register with clamping on write.
  always_comb begin
    wr_val = pwdata[QC_W-1:0];
    cfg_wr = psel && penable && pwrite && !paddr[2];
    if (wr_val == '0) begin
      qubit_count_d = QC_W'(1);
    end else if (wr_val > QC_W'(MAX_QUBITS)) begin
      qubit_count_d = QC_W'(MAX_QUBITS);
    end else begin
      qubit_count_d = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubit_count_q <= QC_W'(1);
    end else if (cfg_wr) begin
      qubit_count_q <= qubit_count_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(qubit_count_q);

  svmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  svmc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .qubit_count_i     (qubit_count_q),
    .kind_i            (req_i.kind),
    .basis_index_i     (req_i.basis_index),
    .amp_real_i        (req_i.amp_real),
    .amp_imag_i        (req_i.amp_imag),
    .target_qubit_i    (req_i.target_qubit),
    .random_fraction_i (req_i.random_fraction),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .probability_o     (rsp_o.probability),
    .outcome_index_o   (rsp_o.outcome_index),
    .outcome_bit_o     (rsp_o.outcome_bit),
    .status_o          (rsp_o.status)
  );

endmodule

`default_nettype wire

// ----- rtl/svmc_checker.sv -----
// Port-level checks of the state vector block and their binding to the top level.
`default_nettype none

module svmc_checker import svmc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [PROB_W-1:0] probability_i,
  input logic [IDX_W-1:0]  outcome_index_i,
  input logic              outcome_bit_i,
  input status_t           status_i
);

  // A stalled response beat keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(probability_i) &&
      $stable(outcome_index_i) && $stable(outcome_bit_i) && $stable(status_i))
    else $error("response changed while stalled");

  // Items are processed one at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted in consecutive cycles");

  // An out-of-range access reports nothing else.
  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_OOR) |->
      (probability_i == '0) && (outcome_index_i == '0) && !outcome_bit_i)
    else $error("out-of-range result carries data");

  // A measured index only comes with a good status and no probability.
  a_index_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (outcome_index_i != '0) |->
      (status_i == STAT_OK) && (probability_i == '0) && !outcome_bit_i)
    else $error("outcome index with unexpected fields");

endmodule

bind state_vector_measure_collapse svmc_checker u_svmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .probability_i   (rsp_o.probability),
  .outcome_index_i (rsp_o.outcome_index),
  .outcome_bit_i   (rsp_o.outcome_bit),
  .status_i        (rsp_o.status)
);

`default_nettype wire
